@@ design/rmq_pkg.sv @@
package rmq_pkg;

  // Table geometry and element width
  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 10;

  // Fixed field widths
  localparam int IDX_BITS  = 10;
  localparam int MEAN_BITS = 10;
  localparam int CMD_BITS  = 2;

  localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS = ADDR_BITS + 1;
  localparam int SUM_BITS   = VALUE_BITS + ADDR_BITS;
  localparam int LEN_BITS   = IDX_BITS + 1;
  localparam int STEP_BITS  = $clog2(SUM_BITS + 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } rmq_command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_HI,
    S_FETCH_LO,
    S_DIVIDE,
    S_REPLY
  } rmq_state_t;

  typedef struct packed {
    logic do_append;
    logic do_clear;
    logic take_query;
    logic latch_hi;
    logic start_div;
    logic push;
  } rmq_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic div_last;
    logic out_free;
  } rmq_status_t;

  // Index field to table address
  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [IDX_BITS-1:0] idx);
    logic [ADDR_BITS+IDX_BITS-1:0] w;
    w = {{ADDR_BITS{1'b0}}, idx};
    return w[ADDR_BITS-1:0];
  endfunction

  // Element field to sum width, keeping only VALUE_BITS bits
  function automatic logic [SUM_BITS-1:0] to_sum(input logic [IDX_BITS-1:0] elem);
    logic [SUM_BITS+IDX_BITS-1:0] w;
    w = {{SUM_BITS{1'b0}}, elem};
    for (int b = 0; b < SUM_BITS + IDX_BITS; b++) begin
      if (b >= VALUE_BITS) begin
        w[b] = 1'b0;
      end
    end
    return w[SUM_BITS-1:0];
  endfunction

  // Quotient to mean field
  function automatic logic [MEAN_BITS-1:0] to_mean(input logic [SUM_BITS-1:0] q);
    logic [SUM_BITS+MEAN_BITS-1:0] w;
    w = {{MEAN_BITS{1'b0}}, q};
    return w[MEAN_BITS-1:0];
  endfunction

endpackage

@@ design/rmq_ram.sv @@
module rmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rmq_div.sv @@
module rmq_div import rmq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [LEN_BITS-1:0] divisor,
  output logic                last,
  output logic [SUM_BITS-1:0] quotient
);

  logic                  active;
  logic [STEP_BITS-1:0]  steps;
  logic [LEN_BITS-1:0]   rem;
  logic [LEN_BITS-1:0]   dvs;
  logic [SUM_BITS-1:0]   quo;
  logic [LEN_BITS:0]     trial;
  logic [LEN_BITS:0]     diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[SUM_BITS-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (start) begin
      active <= 1'b1;
      steps  <= STEP_BITS'(SUM_BITS);
    end else if (active) begin
      steps <= steps - 1'b1;
      if (steps == STEP_BITS'(1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (active) begin
      rem <= fits ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], fits};
    end
  end

  assign last     = active && (steps == STEP_BITS'(1));
  assign quotient = quo;

endmodule

@@ design/rmq_ctrl.sv @@
module rmq_ctrl import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [CMD_BITS-1:0] command,
  input  rmq_status_t  status,
  output rmq_cmd_t     cmd
);

  rmq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (rmq_command_t'(command))
            CMD_APPEND: cmd.do_append = 1'b1;
            CMD_CLEAR:  cmd.do_clear  = 1'b1;
            CMD_QUERY: begin
              cmd.take_query = 1'b1;
              state_next     = status.range_bad ? S_REPLY : S_FETCH_HI;
            end
            default: ;
          endcase
        end
      end
      S_FETCH_HI: begin
        cmd.latch_hi = 1'b1;
        state_next   = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        cmd.start_div = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_last) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input taken outside idle");
`endif

endmodule

@@ design/rmq_datapath.sv @@
module rmq_datapath import rmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_BITS-1:0]  element_value,
  input  logic [IDX_BITS-1:0]  left_index,
  input  logic [IDX_BITS-1:0]  right_index,
  input  rmq_cmd_t             cmd,
  output rmq_status_t          status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MEAN_BITS-1:0] mean_value,
  output logic                 range_error
);

  logic [COUNT_BITS-1:0] count;
  logic [SUM_BITS-1:0]   total;
  logic [SUM_BITS-1:0]   total_next;
  logic                  full;
  logic [IDX_BITS-1:0]   lft;
  logic [IDX_BITS-1:0]   rgt;
  logic                  err;
  logic [SUM_BITS-1:0]   hi;
  logic [SUM_BITS-1:0]   lo;
  logic [SUM_BITS-1:0]   rdata;
  logic [ADDR_BITS-1:0]  raddr;
  logic                  we;
  logic [LEN_BITS-1:0]   len;
  logic                  div_last;
  logic [SUM_BITS-1:0]   quotient;

  assign full       = 32'(count) >= TABLE_DEPTH;
  assign total_next = total + to_sum(element_value);
  assign we         = cmd.do_append && !full;

  // Hold count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
      total <= '0;
    end else if (we) begin
      count <= count + 1'b1;
      total <= total_next;
    end
  end

  // Read the right prefix at accept, the left one from the held index
  assign raddr = cmd.take_query ? to_addr(right_index) : to_addr(lft - 1'b1);

  rmq_ram #(.WIDTH(SUM_BITS), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_BITS-1:0]),
    .wdata (total_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status.range_bad = (left_index > right_index) ||
                            (32'(right_index) >= 32'(count));

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      lft <= left_index;
      rgt <= right_index;
      err <= status.range_bad;
    end
    if (cmd.latch_hi) begin
      hi <= rdata;
    end
  end

  assign lo  = (lft == '0) ? '0 : rdata;
  assign len = {1'b0, rgt} - {1'b0, lft} + LEN_BITS'(1);

  rmq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (hi - lo),
    .divisor  (len),
    .last     (div_last),
    .quotient (quotient)
  );

  assign status.div_last = div_last;
  assign status.out_free = !out_valid || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mean_value  <= err ? '0 : to_mean(quotient);
      range_error <= err;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= TABLE_DEPTH)
    else $error("loaded count past table depth");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result pushed over a pending one");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |=> !div_last)
    else $error("divider finished right after start");
`endif

endmodule

@@ design/range_mean_query_top.sv @@
// Range mean query over a table of prefix sums.
//
// Input channel (in_valid/in_ready) carries a command with element_value,
// left_index and right_index. Append stores the new running total at the
// next index (ignored once the table is full), clear empties the table,
// query answers with floor(sum over [left_index, right_index] / length).
// Command code 3 is dropped. Only a query produces a transfer on the output
// channel (out_valid/out_ready): mean_value, plus range_error when left
// exceeds right or right is not yet loaded (mean_value 0 then).
//
// Append, clear and unused codes are handled at accept. A valid query makes
// one table read per prefix, one load, one restoring divider step per
// quotient bit, then posts the result. A bad range skips the reads and the
// divider and goes straight to posting its result.
// A result sits in an output register; the next item is accepted while it
// waits, and a query stalls only when posting while an earlier result is
// pending and out_ready is low. Synchronous reset empties the table and
// drops any pending result; the table memory itself needs no clearing pass.
module range_mean_query_top import rmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_BITS-1:0]  command,
  input  logic [IDX_BITS-1:0]  element_value,
  input  logic [IDX_BITS-1:0]  left_index,
  input  logic [IDX_BITS-1:0]  right_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MEAN_BITS-1:0] mean_value,
  output logic                 range_error
);

  // Commands from the controller, status back from the datapath
  rmq_cmd_t    cmd;
  rmq_status_t status;

  rmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  rmq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .element_value (element_value),
    .left_index    (left_index),
    .right_index   (right_index),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_value    (mean_value),
    .range_error   (range_error)
  );

endmodule
